FILE: sv/erf_pkg.sv
`timescale 1ns / 1ps
// Package for the echo pulse rangefinder: sizes, reset values, register indexes
// and the command/status structs between controller and datapath. No dependencies.
package erf_pkg;

   localparam int TIMER_BITS_DEF    = 16;
   localparam int OVERFLOW_BITS_DEF = 8;

   localparam int WIDTH_BITS = 24;   // pulse width in ticks / microseconds
   localparam int DIST_BITS  = 16;
   localparam int ZONE_BITS  = 2;
   localparam int DVS_W      = 8;    // divisor width (both divisor registers)
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Shared divider: dividend holds us * 10 (< 2^28), two quotient bits per step
   localparam int DIV_W     = 28;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_US = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_US_PER_MM    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_LOW      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_HIGH     = 2'd3;

   localparam logic [DVS_W-1:0]     TICKS_PER_US_RST = 8'd16;
   localparam logic [DVS_W-1:0]     US_PER_MM_RST    = 8'd58;
   localparam logic [DIST_BITS-1:0] MID_LOW_RST      = 16'd70;
   localparam logic [DIST_BITS-1:0] MID_HIGH_RST     = 16'd120;

   localparam logic [ZONE_BITS-1:0] ZONE_NEAR = 2'd0;
   localparam logic [ZONE_BITS-1:0] ZONE_MID  = 2'd1;
   localparam logic [ZONE_BITS-1:0] ZONE_FAR  = 2'd2;

   localparam logic CMD_OVERFLOW = 1'b0;
   localparam logic CMD_CAPTURE  = 1'b1;

   typedef struct packed {
      logic bump_overflow;   // timer overflow item
      logic capture_start;   // rising-edge capture item
      logic load_div1;       // falling-edge capture: ticks / ticks_per_us
      logic div_step;
      logic load_div2;       // us * 10 / us_per_mm_tenths
      logic load_rsp;
   } erf_cmd_type;

   typedef struct packed {
      logic is_overflow;
      logic is_rise;
   } erf_status_type;

endpackage

FILE: sv/erf_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, two quotient bits per cycle while step is high,
// quotient shifted into the dividend register. Depends on erf_pkg.
module erf_div import erf_pkg::*; (
   input  logic             clock,
   input  logic             load,
   input  logic             step,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient
);

   logic [DIV_W-1:0] num_ff, num_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   r1, r2, d_ext;
   logic [DVS_W-1:0] r1_n;
   logic             q1, q2;

   always_comb begin
      d_ext = {1'b0, dvs_ff};
      r1    = {rem_ff, num_ff[DIV_W-1]};
      q1    = (r1 >= d_ext);
      r1_n  = q1 ? DVS_W'(r1 - d_ext) : r1[DVS_W-1:0];
      r2    = {r1_n, num_ff[DIV_W-2]};
      q2    = (r2 >= d_ext);
      num_in = num_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (load) begin
         num_in = dividend;
         rem_in = '0;
         dvs_in = (divisor == '0) ? DVS_W'(1) : divisor;   // zero treated as one
      end else if (step) begin
         num_in = {num_ff[DIV_W-3:0], q1, q2};
         rem_in = q2 ? DVS_W'(r2 - d_ext) : r2[DVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = num_ff;

endmodule

FILE: sv/erf_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, start stamp, overflow count, tick arithmetic,
// shared divider and result register. Depends on erf_pkg and erf_div.
module erf_dp import erf_pkg::*; #(
   parameter int TIMER_BITS    = TIMER_BITS_DEF,
   parameter int OVERFLOW_BITS = OVERFLOW_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_command,
   input  logic                  req_echo_level,
   input  logic [15:0]           req_capture_time,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  erf_cmd_type           cmd,
   output erf_status_type        status,
   output logic [WIDTH_BITS-1:0] rsp_pulse_us,
   output logic [DIST_BITS-1:0]  rsp_distance_mm,
   output logic [ZONE_BITS-1:0]  rsp_zone
);

   localparam int EXT_W = TIMER_BITS + OVERFLOW_BITS + WIDTH_BITS;

   logic [DVS_W-1:0]         tpu_ff, tpu_in;
   logic [DVS_W-1:0]         upm_ff, upm_in;
   logic [DIST_BITS-1:0]     mid_low_ff, mid_low_in;
   logic [DIST_BITS-1:0]     mid_high_ff, mid_high_in;
   logic [TIMER_BITS-1:0]    start_ff, start_in;
   logic [OVERFLOW_BITS-1:0] ovf_ff, ovf_in;
   logic [WIDTH_BITS-1:0]    us_ff, us_in;
   logic [WIDTH_BITS-1:0]    pulse_ff, pulse_in;
   logic [DIST_BITS-1:0]     dist_ff, dist_in;
   logic [ZONE_BITS-1:0]     zone_ff, zone_in;

   logic [EXT_W-1:0]      ext_sum;
   logic [WIDTH_BITS-1:0] ticks, q_us;
   logic [DIV_W-1:0]      dividend, quotient;
   logic [DVS_W-1:0]      divisor;
   logic [DIST_BITS-1:0]  dist_sat;

   assign status.is_overflow = (req_command == CMD_OVERFLOW);
   assign status.is_rise     = (req_command == CMD_CAPTURE) && req_echo_level;

   // end - start + count * 2^TIMER_BITS, kept to 24 bits
   assign ext_sum = (EXT_W'(ovf_ff) << TIMER_BITS)
                  + EXT_W'(TIMER_BITS'(req_capture_time))
                  - EXT_W'(start_ff);
   assign ticks = ext_sum[WIDTH_BITS-1:0];
   assign q_us  = quotient[WIDTH_BITS-1:0];

   always_comb begin
      if (cmd.load_div2) begin
         dividend = (DIV_W'(q_us) << 3) + (DIV_W'(q_us) << 1);
         divisor  = upm_ff;
      end else begin
         dividend = DIV_W'(ticks);
         divisor  = tpu_ff;
      end
   end

   erf_div u_div (
      .clock    (clock),
      .load     (cmd.load_div1 | cmd.load_div2),
      .step     (cmd.div_step),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient)
   );

   assign dist_sat = (quotient[DIV_W-1:DIST_BITS] != '0) ? '1 : quotient[DIST_BITS-1:0];

   always_comb begin
      tpu_in      = tpu_ff;
      upm_in      = upm_ff;
      mid_low_in  = mid_low_ff;
      mid_high_in = mid_high_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TICKS_PER_US: tpu_in      = csr_data[DVS_W-1:0];
            CSR_US_PER_MM:    upm_in      = csr_data[DVS_W-1:0];
            CSR_MID_LOW:      mid_low_in  = csr_data[DIST_BITS-1:0];
            CSR_MID_HIGH:     mid_high_in = csr_data[DIST_BITS-1:0];
         endcase
      end

      start_in = start_ff;
      ovf_in   = ovf_ff;
      if (cmd.bump_overflow) begin
         ovf_in = ovf_ff + OVERFLOW_BITS'(1);
      end else if (cmd.capture_start) begin
         start_in = TIMER_BITS'(req_capture_time);
         ovf_in   = '0;
      end

      us_in = cmd.load_div2 ? q_us : us_ff;

      pulse_in = pulse_ff;
      dist_in  = dist_ff;
      zone_in  = zone_ff;
      if (cmd.load_rsp) begin
         pulse_in = us_ff;
         dist_in  = dist_sat;
         if (dist_sat >= mid_low_ff && dist_sat <= mid_high_ff) begin
            zone_in = ZONE_MID;
         end else if (dist_sat > mid_high_ff) begin
            zone_in = ZONE_FAR;
         end else begin
            zone_in = ZONE_NEAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff      <= TICKS_PER_US_RST;
         upm_ff      <= US_PER_MM_RST;
         mid_low_ff  <= MID_LOW_RST;
         mid_high_ff <= MID_HIGH_RST;
         start_ff    <= '0;
         ovf_ff      <= '0;
      end else begin
         tpu_ff      <= tpu_in;
         upm_ff      <= upm_in;
         mid_low_ff  <= mid_low_in;
         mid_high_ff <= mid_high_in;
         start_ff    <= start_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      us_ff    <= us_in;
      pulse_ff <= pulse_in;
      dist_ff  <= dist_in;
      zone_ff  <= zone_in;
   end

   assign rsp_pulse_us    = pulse_ff;
   assign rsp_distance_mm = dist_ff;
   assign rsp_zone        = zone_ff;

endmodule

FILE: sv/erf_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences item intake, the two divisions and the result handoff.
// Depends on erf_pkg.
module erf_ctrl import erf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  erf_status_type status,
   output erf_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV1  = 3'd1;
   localparam logic [2:0] S_LOAD2 = 3'd2;
   localparam logic [2:0] S_DIV2  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             last_step, accept, out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign last_step = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (status.is_overflow) begin
                  cmd.bump_overflow = 1'b1;
               end else if (status.is_rise) begin
                  cmd.capture_start = 1'b1;
               end else begin
                  cmd.load_div1 = 1'b1;
                  cnt_in        = '0;
                  state_in      = S_DIV1;
               end
            end
         end
         S_DIV1: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (last_step) state_in = S_LOAD2;
         end
         S_LOAD2: begin
            cmd.load_div2 = 1'b1;
            cnt_in        = '0;
            state_in      = S_DIV2;
         end
         S_DIV2: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (last_step) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/echo_pulse_rangefinder.sv
`timescale 1ns / 1ps
// Echo pulse rangefinder top level: controller plus datapath.
// Depends on erf_pkg, erf_ctrl, erf_dp (and erf_div below it).
//
// Items are timer events. An overflow item (command 0) bumps the wrapping
// overflow count and a rising-edge capture (command 1, echo_level 1) stores
// the start stamp and clears that count; both leave the block idle and give no
// result. A falling-edge capture computes ticks = end - start + count *
// 2^TIMER_BITS (mod 2^24), then pulse_us = ticks / ticks_per_us and
// distance_mm = pulse_us * 10 / us_per_mm_tenths (saturated at 65535), plus
// a near/middle/far zone from the two thresholds. A zero divisor register
// acts as one. Both divisions run on one shared divider that retires two
// quotient bits per cycle. A falling-edge item is accepted with the first
// divider load, then runs the first division, the second divider load and
// the second division; req_ready stays low until the result load. The result
// sits in an output register, so overflow and rising-edge items are still
// taken while it waits for rsp_ready; a following falling-edge item is
// computed but holds, with req_ready low, until that register frees.
// Configuration writes take effect at once and should only be made while
// no measurement is in flight.
module echo_pulse_rangefinder import erf_pkg::*; #(
   parameter int TIMER_BITS    = TIMER_BITS_DEF,
   parameter int OVERFLOW_BITS = OVERFLOW_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // event items
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic                  req_echo_level,
   input  logic [15:0]           req_capture_time,
   // measurement items
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WIDTH_BITS-1:0] rsp_pulse_us,
   output logic [DIST_BITS-1:0]  rsp_distance_mm,
   output logic [ZONE_BITS-1:0]  rsp_zone,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   erf_cmd_type    cmd;
   erf_status_type status;

   erf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   erf_dp #(
      .TIMER_BITS    (TIMER_BITS),
      .OVERFLOW_BITS (OVERFLOW_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_echo_level   (req_echo_level),
      .req_capture_time (req_capture_time),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_pulse_us     (rsp_pulse_us),
      .rsp_distance_mm  (rsp_distance_mm),
      .rsp_zone         (rsp_zone)
   );

endmodule

FILE: sv/erf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the echo pulse rangefinder, bound to the top level.
// Depends on erf_pkg.
module erf_checker import erf_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_command,
   input logic                  req_echo_level,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [WIDTH_BITS-1:0] rsp_pulse_us,
   input logic [DIST_BITS-1:0]  rsp_distance_mm,
   input logic [ZONE_BITS-1:0]  rsp_zone
);

   logic       fall_acc, out_acc;
   logic [1:0] pend_ff, pend_in;

   assign fall_acc = req_valid && req_ready && (req_command == CMD_CAPTURE) && !req_echo_level;
   assign out_acc  = rsp_valid && rsp_ready;

   // falling-edge items accepted but not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (fall_acc && !out_acc) pend_in = pend_ff + 2'd1;
      else if (!fall_acc && out_acc) pend_in = pend_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) pend_ff <= '0;
      else       pend_ff <= pend_in;
   end

   a_no_phantom_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a pending falling-edge capture");

   a_busy_after_fall: assert property (@(posedge clock) disable iff (reset)
      fall_acc |=> !req_ready)
      else $error("input still ready while a measurement is in progress");

   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({12'd0, rsp_distance_mm} <= ({4'd0, rsp_pulse_us} * 28'd10)))
      else $error("distance exceeds ten times the pulse width");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pulse_us)
         && $stable(rsp_distance_mm) && $stable(rsp_zone))
      else $error("stalled result changed or dropped");

endmodule

bind echo_pulse_rangefinder erf_checker u_erf_checker (.*);

FILE: tb/echo_pulse_rangefinder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for echo_pulse_rangefinder: timer event items in, range items out.
// Depends on erf_pkg and the echo_pulse_rangefinder RTL; needs nothing else.
module echo_pulse_rangefinder_tb;
   import erf_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 4;
   // Pause that lets a falling-edge capture finish before any register write
   // and at the end.
   localparam int DRAIN_CYCLES = 40;
   // Several times the slowest run: ~2000 items, each at the longest busy
   // time plus the longest send gap and result stall.
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_ITEMS = 1950;
   localparam int CHUNK_ITEMS  = 150;
   localparam int MAX_REPORTS  = 40;

   localparam logic ECHO_RISING  = 1'b1;
   localparam logic ECHO_FALLING = 1'b0;
   localparam logic [DIST_BITS-1:0] DIST_SAT = '1;

   typedef struct packed {
      logic        command;
      logic        echo_level;
      logic [15:0] capture_time;
   } timer_event_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0] pulse_us;
      logic [DIST_BITS-1:0]  distance_mm;
      logic [ZONE_BITS-1:0]  zone;
   } range_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic                  req_command      = CMD_OVERFLOW;
   logic                  req_echo_level   = ECHO_FALLING;
   logic [15:0]           req_capture_time = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [WIDTH_BITS-1:0] rsp_pulse_us;
   logic [DIST_BITS-1:0]  rsp_distance_mm;
   logic [ZONE_BITS-1:0]  rsp_zone;
   logic                  csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = CSR_TICKS_PER_US;
   logic [CSR_DATA_W-1:0] csr_data         = '0;

   // Items waiting to be sent, and ranges the predictor says are still owed.
   timer_event_type events_to_send[$];
   range_type       ranges_due[$];

   int queued_count   = 0;
   int accepted_count = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   bit req_idle_on    = 1'b0;
   bit rsp_idle_on    = 1'b0;

   // Shadow copy of the block's registers and measurement state.
   logic [DVS_W-1:0]     cfg_ticks_per_us = TICKS_PER_US_RST;
   logic [DVS_W-1:0]     cfg_us_per_mm    = US_PER_MM_RST;
   logic [DIST_BITS-1:0] cfg_mid_low      = MID_LOW_RST;
   logic [DIST_BITS-1:0] cfg_mid_high     = MID_HIGH_RST;
   logic [15:0]          start_stamp      = '0;
   logic [7:0]           overflow_count   = '0;

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   echo_pulse_rangefinder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_echo_level   (req_echo_level),
      .req_capture_time (req_capture_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pulse_us     (rsp_pulse_us),
      .rsp_distance_mm  (rsp_distance_mm),
      .rsp_zone         (rsp_zone),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int pick_gap(bit enable);
      int r;
      if (!enable) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Advances the shadow state by one accepted item; a falling-edge capture
   // owes one range item.
   function automatic void track_event(timer_event_type ev);
      logic [31:0]           span;
      logic [WIDTH_BITS-1:0] pulse;
      logic [31:0]           scaled;
      logic [DVS_W-1:0]      dvs;
      range_type             r;
      if (ev.command == CMD_OVERFLOW) begin
         overflow_count = overflow_count + 8'd1;   // wraps at 256
         return;
      end
      if (ev.echo_level == ECHO_RISING) begin
         start_stamp    = ev.capture_time;
         overflow_count = '0;
         return;
      end
      // width in ticks, mod 2^24; end before start wraps to a huge width
      span  = {16'd0, ev.capture_time} + {8'd0, overflow_count, 16'd0}
              - {16'd0, start_stamp};
      dvs   = (cfg_ticks_per_us == '0) ? 8'd1 : cfg_ticks_per_us;
      pulse = span[WIDTH_BITS-1:0] / dvs;
      dvs    = (cfg_us_per_mm == '0) ? 8'd1 : cfg_us_per_mm;
      scaled = ({8'd0, pulse} * 32'd10) / {24'd0, dvs};
      r.pulse_us    = pulse;
      r.distance_mm = (scaled > {16'd0, DIST_SAT}) ? DIST_SAT : scaled[DIST_BITS-1:0];
      // inverted thresholds leave the middle zone empty
      if (r.distance_mm >= cfg_mid_low && r.distance_mm <= cfg_mid_high)
         r.zone = ZONE_MID;
      else if (r.distance_mm > cfg_mid_high)
         r.zone = ZONE_FAR;
      else
         r.zone = ZONE_NEAR;
      ranges_due.push_back(r);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Event driver. Valid stays up with a steady payload until taken; the
   // shadow model advances on the same edge the block takes the item.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : event_driver
      timer_event_type ev;
      bit              holding;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         holding = req_valid;
         if (req_valid && req_ready) begin
            track_event({req_command, req_echo_level, req_capture_time});
            accepted_count++;
            holding = 1'b0;
         end
         if (!holding) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (events_to_send.size() > 0) begin
               ev = events_to_send.pop_front();
               req_command      <= ev.command;
               req_echo_level   <= ev.echo_level;
               req_capture_time <= ev.capture_time;
               req_valid        <= 1'b1;
               send_gap = pick_gap(req_idle_on);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Range monitor: checks each taken result against the oldest owed one
   // and stalls rsp_ready at random, including while results sit waiting.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : range_monitor
      range_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (ranges_due.size() == 0) begin
               report_mismatch("range item with none owed, pulse_us", rsp_pulse_us, -1);
            end else begin
               want = ranges_due.pop_front();
               if (rsp_pulse_us !== want.pulse_us)
                  report_mismatch("pulse_us", rsp_pulse_us, want.pulse_us);
               if (rsp_distance_mm !== want.distance_mm)
                  report_mismatch("distance_mm", rsp_distance_mm, want.distance_mm);
               if (rsp_zone !== want.zone)
                  report_mismatch("zone", rsp_zone, want.zone);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = pick_gap(1'b1);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("echo_pulse_rangefinder: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_event(logic cmd, logic lvl, logic [15:0] stamp);
      events_to_send.push_back('{command: cmd, echo_level: lvl, capture_time: stamp});
      queued_count++;
   endtask

   // Everything sent has been taken, nothing is owed, and the block has had
   // time to finish any item that gives no result.
   task automatic wait_idle();
      while (!(accepted_count == queued_count && ranges_due.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register writes, one per edge; only called while idle.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         CSR_TICKS_PER_US: cfg_ticks_per_us = data[DVS_W-1:0];
         CSR_US_PER_MM:    cfg_us_per_mm    = data[DVS_W-1:0];
         CSR_MID_LOW:      cfg_mid_low      = data;
         CSR_MID_HIGH:     cfg_mid_high     = data;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [15:0] tpu, logic [15:0] upm,
                             logic [15:0] lo, logic [15:0] hi);
      write_reg(CSR_TICKS_PER_US, tpu);
      write_reg(CSR_US_PER_MM, upm);
      write_reg(CSR_MID_LOW, lo);
      write_reg(CSR_MID_HIGH, hi);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [DVS_W-1:0] pick_divisor();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'd0;      // zero acts as one
      if (r == 1) return 8'd1;
      if (r == 2) return 8'd255;
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic random_config();
      int          r;
      logic [15:0] lo, hi;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         lo = 16'($urandom_range(0, 600));
         hi = lo + 16'($urandom_range(0, 600));
      end else if (r < 8) begin
         hi = 16'($urandom_range(0, 500));
         lo = hi + 16'($urandom_range(1, 500));
      end else begin
         lo = 16'($urandom);
         hi = 16'($urandom);
      end
      // upper data bits on the 8-bit registers are junk the block drops
      set_config({8'($urandom), pick_divisor()}, {8'($urandom), pick_divisor()}, lo, hi);
   endtask

   // Rising edge, some overflows, one or more falling edges from that start.
   task automatic queue_measurement(bit wrap_run);
      int          r, n_ovf, n_fall, i;
      logic [15:0] t0, t1;
      r  = $urandom_range(0, 9);
      t0 = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
      queue_event(CMD_CAPTURE, ECHO_RISING, t0);
      r = $urandom_range(0, 99);
      if (wrap_run || $urandom_range(0, 399) == 0) n_ovf = $urandom_range(254, 258);
      else if (r < 40) n_ovf = 0;
      else if (r < 75) n_ovf = 1;
      else if (r < 93) n_ovf = $urandom_range(2, 4);
      else             n_ovf = $urandom_range(5, 20);
      for (i = 0; i < n_ovf; i++)
         queue_event(CMD_OVERFLOW, 1'($urandom), 16'($urandom));
      n_fall = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
      for (i = 0; i < n_fall; i++) begin
         t1 = $urandom_range(0, 1) ? t0 + 16'($urandom_range(0, 20000)) : 16'($urandom);
         queue_event(CMD_CAPTURE, ECHO_FALLING, t1);
      end
   endtask

   task automatic queue_noise();
      int i, n;
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++)
         queue_event(1'($urandom), 1'($urandom), 16'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Main sequence: reset, directed items on reset values, then chunks of
   // random measurements, each under its own register setting.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int chunk, base, chunk_end;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // falling edge with no rising edge yet: measures from a start of zero
      queue_event(CMD_CAPTURE, ECHO_FALLING, 16'h0000);
      queue_event(CMD_CAPTURE, ECHO_FALLING, 16'hFFFF);
      // overflow item with its other fields all ones, which must be ignored
      queue_event(CMD_OVERFLOW, ECHO_RISING, 16'hFFFF);
      queue_event(CMD_CAPTURE, ECHO_FALLING, 16'h0000);
      // end stamp before start stamp with no overflow: width wraps
      queue_event(CMD_CAPTURE, ECHO_RISING, 16'hFFFF);
      queue_event(CMD_CAPTURE, ECHO_FALLING, 16'h0000);
      // zone boundaries at default scaling: 69, 70, 120, 121 mm
      queue_event(CMD_CAPTURE, ECHO_RISING, 16'h0000);
      queue_event(CMD_CAPTURE, ECHO_FALLING, 16'd6416);
      queue_event(CMD_CAPTURE, ECHO_FALLING, 16'd6496);
      queue_event(CMD_CAPTURE, ECHO_FALLING, 16'd11136);
      queue_event(CMD_CAPTURE, ECHO_FALLING, 16'd11232);
      queue_event(CMD_OVERFLOW, ECHO_FALLING, 16'h0000);
      queue_event(CMD_OVERFLOW, ECHO_RISING, 16'h5A5A);
      queue_event(CMD_CAPTURE, ECHO_FALLING, 16'hFFFF);
      queue_event(CMD_CAPTURE, ECHO_RISING, 16'hA5A5);
      queue_event(CMD_OVERFLOW, ECHO_FALLING, 16'h5A5A);
      queue_event(CMD_CAPTURE, ECHO_FALLING, 16'h5A5A);

      base  = queued_count;
      chunk = 0;
      while (queued_count - base < RANDOM_ITEMS) begin
         wait_idle();
         case (chunk)
            // smallest divisors, middle zone covers everything, distance saturates
            0: set_config(16'h0001, 16'h0001, 16'h0000, 16'hFFFF);
            // largest divisors, inverted thresholds
            1: set_config(16'hFFFF, 16'h00FF, 16'hFFFF, 16'h0000);
            // zero divisors with junk upper bits
            2: set_config(16'hFF00, 16'h5500, 16'h0000, 16'h0000);
            default: random_config();
         endcase
         // chunk 1 runs with no idling at all on either side
         req_idle_on = (chunk != 1) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (chunk != 1) && ($urandom_range(0, 3) != 0);
         chunk_end = queued_count + CHUNK_ITEMS;
         // chunk 3 opens with a run of 254 to 258 overflows, around the wrap of the overflow count
         if (chunk == 3) queue_measurement(1'b1);
         while (queued_count < chunk_end) begin
            if ($urandom_range(0, 99) < 80) queue_measurement(1'b0);
            else                            queue_noise();
         end
         chunk++;
      end

      wait_idle();
      if (error_count == 0)
         $display("echo_pulse_rangefinder: match");
      else
         $display("echo_pulse_rangefinder: mismatch");
      $finish;
   end

endmodule
